### rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle unit.
package qte_pkg;

	// Widths of the internal datapath
	localparam int OPW  = 34;   // doubled products and sums, signed
	localparam int CW   = 37;   // CORDIC x and y, signed, room for gain
	localparam int ZW   = 28;   // CORDIC angle accumulator, signed Q24
	localparam int AW   = 30;   // saturated arcsine argument, signed Q28
	localparam int RW   = 57;   // square root radicand
	localparam int SQW  = 29;   // square root result
	localparam int TABN = 24;   // entries of the arctangent table

	localparam logic signed [ZW-1:0] ANG_PI = 28'sd52707179;

	// atan(2^-i) in Q24 radians
	localparam logic [24:0] ATAN_TAB [TABN] = '{
		25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214,
		25'd524117, 25'd262123, 25'd131069, 25'd65536, 25'd32768,
		25'd16384, 25'd8192, 25'd4096, 25'd2048, 25'd1024, 25'd512,
		25'd256, 25'd128, 25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2
	};

	// Operands that ride beside the square root
	typedef struct packed {
		logic signed [AW-1:0]  asin_arg;
		logic signed [OPW-1:0] pitch_y;
		logic signed [OPW-1:0] pitch_x;
		logic signed [OPW-1:0] yaw_y;
		logic signed [OPW-1:0] yaw_x;
	} side_t;

endpackage

### rtl/qte_front.sv
// Front end: products, sums, saturation and the square root radicand.
module qte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [63:0]         in_data,
	output logic                out_valid,
	output logic [56:0]         out_rem,
	output qte_pkg::side_t      out_side
);
	import qte_pkg::*;

	logic signed [15:0] qw, qx, qy, qz;
	logic signed [31:0] wy_s1, xz_s1, yz_s1, wx_s1, xy_s1, wz_s1, ww_s1, xx_s1, zz_s1;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [OPW-1:0] asum;
	logic signed [AW-1:0]  asat;
	logic [SQW-1:0]     aabs_s2;
	side_t              side_s2, side_s3, side_s4;
	logic [2*SQW-1:0]   aa_s3;
	logic [RW-1:0]      rem_s4;

	assign qw = in_data[15:0];
	assign qx = in_data[31:16];
	assign qy = in_data[47:32];
	assign qz = in_data[63:48];

	// Form all products
	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= qw * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			xy_s1 <= qx * qy;
			wz_s1 <= qw * qz;
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			zz_s1 <= qz * qz;
		end
	end

	// Saturate the arcsine argument to plus or minus one
	always_comb begin
		asum = (OPW'(xz_s1) + OPW'(wy_s1)) <<< 1;
		if (asum > OPW'(64'sd268435456))
			asat = AW'(64'sd268435456);
		else if (asum < -OPW'(64'sd268435456))
			asat = -AW'(64'sd268435456);
		else
			asat = AW'(asum);
	end

	// Combine into the angle operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.asin_arg <= asat;
			side_s2.pitch_y  <= (OPW'(yz_s1) - OPW'(wx_s1)) <<< 1;
			side_s2.pitch_x  <= ((OPW'(ww_s1) + OPW'(zz_s1)) <<< 1) - OPW'(64'sd268435456);
			side_s2.yaw_y    <= (OPW'(xy_s1) - OPW'(wz_s1)) <<< 1;
			side_s2.yaw_x    <= ((OPW'(ww_s1) + OPW'(xx_s1)) <<< 1) - OPW'(64'sd268435456);
			aabs_s2          <= asat[AW-1] ? SQW'(-asat) : SQW'(asat);
		end
	end

	// Square the argument, then subtract from one
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s3   <= aabs_s2 * aabs_s2;
			side_s3 <= side_s2;
			rem_s4  <= (RW'(1) << 56) - aa_s3[RW-1:0];
			side_s4 <= side_s3;
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_rem   = rem_s4;
	assign out_side  = side_s4;

endmodule

### rtl/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module qte_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [56:0]         in_rem,
	input  qte_pkg::side_t      in_side,
	output logic                out_valid,
	output logic [28:0]         out_root,
	output qte_pkg::side_t      out_side
);
	import qte_pkg::*;

	localparam int NST = SQW;

	logic [RW-1:0] n_s   [NST+1];
	logic [RW-1:0] res_s [NST+1];
	logic          v_s   [NST+1];
	side_t         side_s[NST+1];

	assign n_s[0]    = in_rem;
	assign res_s[0]  = '0;
	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
		logic [RW-1:0] sum;

		assign sum = res_s[k] + BIT;

		// Try the next root bit
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_s[k] >= sum) begin
					n_s[k+1]   <= n_s[k] - sum;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1]   <= n_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	assign out_valid = v_s[NST];
	assign out_root  = res_s[NST][SQW-1:0];
	assign out_side  = side_s[NST];

endmodule

### rtl/qte_cordic.sv
// Pipelined vectoring CORDIC computing atan2(y, x) in Q24 radians.
module qte_cordic #(
	parameter int STAGES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [36:0]         in_y,
	input  logic signed [36:0]         in_x,
	output logic                       out_valid,
	output logic signed [27:0]         out_ang
);
	import qte_pkg::*;

	logic signed [CW-1:0] x_s [STAGES+1];
	logic signed [CW-1:0] y_s [STAGES+1];
	logic signed [ZW-1:0] z_s [STAGES+1];
	logic                 zero_s [STAGES+1];
	logic                 v_s [STAGES+1];

	// Fold the left half plane over and note the degenerate origin
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				x_s[0] <= -in_x;
				y_s[0] <= -in_y;
				z_s[0] <= (in_y >= 0) ? ANG_PI : -ANG_PI;
			end else begin
				x_s[0] <= in_x;
				y_s[0] <= in_y;
				z_s[0] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
		logic signed [CW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		// Rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ANG;
				end
				zero_s[i+1] <= zero_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_ang   = zero_s[STAGES] ? '0 : z_s[STAGES];

endmodule

### rtl/quaternion_to_euler_angles_unit.sv
// Throughput: one quaternion per cycle while no result waits on m_tready;
// the 29-stage square root and the CORDIC stages are fully pipelined, and one
// enable stalls all stages together.
// Reset: arst_n clears every valid bit asynchronously; data registers keep
// whatever they hold.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // roll_rad[14:0], pitch_rad[30:15], yaw_rad[46:31], 0
);
	import qte_pkg::*;

	logic            en;
	logic            f_valid, r_valid, roll_v, pitch_v, yaw_v;
	logic [RW-1:0]   f_rem;
	side_t           f_side, r_side;
	logic [SQW-1:0]  r_root;
	logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
	logic            v_q;
	logic [14:0]     roll_q;
	logic [15:0]     pitch_q, yaw_q;

	// Round Q24 to Q13 half up and clamp to the given limit
	function automatic logic signed [15:0] to_q13(input logic signed [ZW:0] a,
	                                              input logic signed [15:0] lim);
		logic signed [ZW:0] r;
		r = (a + (ZW+1)'(1024)) >>> 11;
		if (r > (ZW+1)'(lim))
			return lim;
		else if (r < -(ZW+1)'(lim))
			return -lim;
		else
			return r[15:0];
	endfunction

	// Stall every stage while a result waits
	assign en       = !v_q || m_tready;
	assign s_tready = en;

	qte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.out_valid(f_valid),
		.out_rem  (f_rem),
		.out_side (f_side)
	);

	qte_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.in_rem   (f_rem),
		.in_side  (f_side),
		.out_valid(r_valid),
		.out_root (r_root),
		.out_side (r_side)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_y     (CW'(r_side.asin_arg)),
		.in_x     (CW'(signed'({1'b0, r_root}))),
		.out_valid(roll_v),
		.out_ang  (roll_z)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_y     (CW'(r_side.pitch_y)),
		.in_x     (CW'(r_side.pitch_x)),
		.out_valid(pitch_v),
		.out_ang  (pitch_z)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_y     (CW'(r_side.yaw_y)),
		.in_x     (CW'(r_side.yaw_x)),
		.out_valid(yaw_v),
		.out_ang  (yaw_z)
	);

	// Output register: negate roll, round and clamp all three
	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= 15'(to_q13(-(ZW+1)'(roll_z), 16'sd12868));
			pitch_q <= to_q13((ZW+1)'(pitch_z), 16'sd25736);
			yaw_q   <= to_q13((ZW+1)'(yaw_z), 16'sd25736);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= roll_v && pitch_v && yaw_v;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};

endmodule

### rtl/qte_checker.sv
// Port-level checks for the quaternion to Euler angle unit, with its bind.
module qte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Accept a request whenever the output can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// Keep roll within plus or minus half pi and the pad bit clear
	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[47] &&
			($signed(m_tdata[14:0]) <= 15'sd12868) &&
			($signed(m_tdata[14:0]) >= -15'sd12868))
		else $error("roll out of range");

	// Keep pitch and yaw within plus or minus pi
	a_ang: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:15]) >= -16'sd25736) &&
			($signed(m_tdata[30:15]) <= 16'sd25736) &&
			($signed(m_tdata[46:31]) >= -16'sd25736) &&
			($signed(m_tdata[46:31]) <= 16'sd25736))
		else $error("pitch or yaw out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
